/* sv/pess_pkg.sv */
package pess_pkg;

	// Fixed field widths of the item and result words
	localparam int PERIOD_W    = 16;
	localparam int SLOT_W      = 4;
	localparam int LEVEL_IN_W  = 2;
	localparam int KIND_W      = 3;

	// Most slots reported by one dispatch
	localparam int MAX_RESULTS = 16;
	localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

	// Command codes
	localparam logic [1:0] CMD_REG   = 2'd0;
	localparam logic [1:0] CMD_UNREG = 2'd1;
	localparam logic [1:0] CMD_DISP  = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_REG   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_UNREG = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIRED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NONE  = 3'd5;

	// Controller to datapath
	typedef struct packed {
		logic load_in;   // capture the input word
		logic start;     // clear scan index and pipeline
		logic set_full;  // answer: table full
		logic set_bad;   // answer: bad slot
		logic rscan;     // search for a free slot
		logic uscan;     // walk and compact the order list
		logic dscan;     // walk the order list and fire
		logic finish;    // hand the final result to the output register
	} pess_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       bad_slot;
		logic       rscan_hit;
		logic       uscan_done;
		logic       dscan_done;
		logic       out_free;
	} pess_stat_t;

endpackage

/* sv/pess_ram.sv */
module pess_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/pess_ctrl.sv */
module pess_ctrl import pess_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pess_stat_t stat,
	output pess_cmd_t  ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RSCAN,
		ST_USCAN,
		ST_DSCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.load_in = in_valid && ready_q;
			end
			ST_DECODE: begin
				case (stat.cmd)
					CMD_REG: begin
						ctl.set_full = stat.full;
						ctl.start    = !stat.full;
					end
					CMD_UNREG: begin
						ctl.set_bad = stat.bad_slot;
						ctl.start   = !stat.bad_slot;
					end
					CMD_DISP: begin
						ctl.start = 1'b1;
					end
					default: ;
				endcase
			end
			ST_RSCAN:  ctl.rscan  = 1'b1;
			ST_USCAN:  ctl.uscan  = 1'b1;
			ST_DSCAN:  ctl.dscan  = 1'b1;
			ST_FINISH: ctl.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_DECODE;
						ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					case (stat.cmd)
						CMD_REG:   state_q <= stat.full ? ST_FINISH : ST_RSCAN;
						CMD_UNREG: state_q <= stat.bad_slot ? ST_FINISH : ST_USCAN;
						CMD_DISP:  state_q <= ST_DSCAN;
						default: begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					endcase
				end
				ST_RSCAN: begin
					if (stat.rscan_hit) begin
						state_q <= ST_FINISH;
					end
				end
				ST_USCAN: begin
					if (stat.uscan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_DSCAN: begin
					if (stat.dscan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* sv/pess_datapath.sv */
module pess_datapath import pess_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int COUNT_WIDTH = 16,
	parameter int LEVEL_WIDTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pess_cmd_t             ctl,
	output pess_stat_t            stat,
	input  logic [1:0]            cmd,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [PERIOD_W-1:0]   period,
	input  logic [LEVEL_IN_W-1:0] level,
	input  logic                  tick,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [SLOT_W-1:0]     slot_id,
	output logic                  timer_running,
	output logic                  last
);

	localparam int SW    = $clog2(NUM_SLOTS);
	localparam int UW    = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

	typedef struct packed {
		logic [PERIOD_W-1:0]    period;
		logic [COUNT_WIDTH-1:0] count;
		logic [LEVEL_WIDTH-1:0] level;
		logic                   pending;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Captured input word
	logic [1:0]            cmd_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [LEVEL_IN_W-1:0] level_q;
	logic                  tick_q;

	// Slot bookkeeping
	logic [NUM_SLOTS-1:0]  valid_q;
	logic [UW-1:0]         used_q;
	logic [UW-1:0]         rd_idx_q;
	logic                  found_q;
	logic [NCNT_W-1:0]     fire_cnt_q;

	// Walk pipeline
	logic                  valid_s1;
	logic                  valid_s2;
	logic [SW-1:0]         ord_idx_s1;
	logic [SW-1:0]         slot_s2;

	// Pending answer and output register
	logic [KIND_W-1:0]     resp_kind_q;
	logic [SLOT_W-1:0]     resp_id_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [SLOT_W-1:0]     slot_id_q;
	logic                  running_q;
	logic                  last_q;

	logic [SW-1:0]         slot_sel;
	logic [SW-1:0]         rd_slot;
	logic                  more;
	logic                  out_free;
	logic                  rscan_hit;
	logic                  uscan_done;
	logic                  dscan_done;
	logic                  ord_issue;
	logic                  rd_idx_inc;
	logic                  stall;
	logic                  adv;
	logic                  fire;
	logic                  push_fire;
	logic                  push_out;
	logic                  load_final;
	logic                  running_now;

	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [PERIOD_W-1:0]    per_eff;
	logic                   reach;
	logic                   pend_new;
	logic [LEVEL_WIDTH-1:0] min_level;

	rec_t                  rec_rd;
	rec_t                  rec_upd;
	rec_t                  rec_new;
	logic                  rec_wr_en;
	logic [SW-1:0]         rec_wr_addr;
	rec_t                  rec_wr_data;
	logic                  rec_rd_en;

	logic [SW-1:0]         ord_rdata;
	logic                  ord_wr_en;
	logic [SW-1:0]         ord_wr_addr;
	logic [SW-1:0]         ord_wr_data;

	assign slot_sel    = SW'(slot_q);
	assign rd_slot     = rd_idx_q[SW-1:0];
	assign more        = rd_idx_q < used_q;
	assign out_free    = !out_valid_q || out_ready;
	assign running_now = used_q != '0;
	assign min_level   = LEVEL_WIDTH'(level_q);

	assign rscan_hit  = ctl.rscan && !valid_q[rd_slot];
	assign uscan_done = ctl.uscan && !more && !valid_s1;
	assign dscan_done = ctl.dscan && !more && !valid_s1 && !valid_s2;

	// Tick and fire decision for the slot in the last stage
	always_comb begin
		cnt_inc  = rec_rd.count + COUNT_WIDTH'(1);
		per_eff  = (rec_rd.period == '0) ? PERIOD_W'(1) : rec_rd.period;
		reach    = CMP_W'(cnt_inc) >= CMP_W'(per_eff);
		rec_upd  = rec_rd;
		pend_new = rec_rd.pending;
		if (tick_q) begin
			if (reach) begin
				rec_upd.count = '0;
				pend_new      = 1'b1;
			end else begin
				rec_upd.count = cnt_inc;
			end
		end
		fire = pend_new && (rec_rd.level >= min_level)
			&& (fire_cnt_q < NCNT_W'(MAX_RESULTS));
		rec_upd.pending = pend_new && !fire;
	end

	// Hold the walk while an earlier firing cannot leave
	assign stall     = ctl.dscan && valid_s2 && fire && (resp_kind_q == KIND_FIRED)
		&& !out_free;
	assign adv       = !stall;
	assign push_fire = ctl.dscan && adv && valid_s2 && fire;
	assign push_out  = push_fire && (resp_kind_q == KIND_FIRED);
	assign load_final = ctl.finish && out_free;

	assign ord_issue  = (ctl.uscan || (ctl.dscan && adv)) && more;
	assign rd_idx_inc = ord_issue || (ctl.rscan && valid_q[rd_slot]);

	always_comb begin
		rec_new         = '0;
		rec_new.period  = period_q;
		rec_new.level   = min_level;
	end

	assign rec_wr_en   = rscan_hit || (ctl.dscan && adv && valid_s2);
	assign rec_wr_addr = rscan_hit ? rd_slot : slot_s2;
	assign rec_wr_data = rscan_hit ? rec_new : rec_upd;
	assign rec_rd_en   = ctl.dscan && adv && valid_s1;

	assign ord_wr_en   = rscan_hit || (ctl.uscan && valid_s1 && found_q);
	assign ord_wr_addr = rscan_hit ? used_q[SW-1:0] : ord_idx_s1 - SW'(1);
	assign ord_wr_data = rscan_hit ? rd_slot : ord_rdata;

	pess_ram #(
		.WIDTH(SW),
		.DEPTH(NUM_SLOTS)
	) u_order (
		.clk    (clk),
		.wr_en  (ord_wr_en),
		.wr_addr(ord_wr_addr),
		.wr_data(ord_wr_data),
		.rd_en  (ord_issue),
		.rd_addr(rd_slot),
		.rd_data(ord_rdata)
	);

	pess_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_SLOTS)
	) u_rec (
		.clk    (clk),
		.wr_en  (rec_wr_en),
		.wr_addr(rec_wr_addr),
		.wr_data(rec_wr_data),
		.rd_en  (rec_rd_en),
		.rd_addr(ord_rdata),
		.rd_data(rec_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			used_q      <= '0;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			fire_cnt_q  <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				rd_idx_q   <= '0;
				found_q    <= 1'b0;
				fire_cnt_q <= '0;
				valid_s1   <= 1'b0;
				valid_s2   <= 1'b0;
			end else begin
				if (rd_idx_inc) begin
					rd_idx_q <= rd_idx_q + UW'(1);
				end
				if (ctl.uscan) begin
					valid_s1 <= ord_issue;
					if (valid_s1 && ord_rdata == slot_sel) begin
						found_q <= 1'b1;
					end
				end
				if (ctl.dscan && adv) begin
					valid_s1 <= ord_issue;
					valid_s2 <= valid_s1;
				end
				if (push_fire) begin
					fire_cnt_q <= fire_cnt_q + NCNT_W'(1);
				end
			end
			if (rscan_hit) begin
				valid_q[rd_slot] <= 1'b1;
				used_q           <= used_q + UW'(1);
			end
			if (uscan_done) begin
				valid_q[slot_sel] <= 1'b0;
				used_q            <= used_q - UW'(1);
			end
			if (load_final || push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q    <= cmd;
			slot_q   <= slot;
			period_q <= period;
			level_q  <= level;
			tick_q   <= tick;
		end
		if (ord_issue) begin
			ord_idx_s1 <= rd_slot;
		end
		if (rec_rd_en) begin
			slot_s2 <= ord_rdata;
		end
		if (ctl.start) begin
			resp_kind_q <= KIND_NONE;
			resp_id_q   <= '0;
		end else if (ctl.set_full) begin
			resp_kind_q <= KIND_FULL;
			resp_id_q   <= '0;
		end else if (ctl.set_bad) begin
			resp_kind_q <= KIND_BAD;
			resp_id_q   <= slot_q;
		end else if (rscan_hit) begin
			resp_kind_q <= KIND_REG;
			resp_id_q   <= SLOT_W'(rd_slot);
		end else if (uscan_done) begin
			resp_kind_q <= KIND_UNREG;
			resp_id_q   <= slot_q;
		end else if (push_fire) begin
			resp_kind_q <= KIND_FIRED;
			resp_id_q   <= SLOT_W'(slot_s2);
		end
		if (load_final || push_out) begin
			kind_q    <= resp_kind_q;
			slot_id_q <= resp_id_q;
			running_q <= running_now;
			last_q    <= load_final;
		end
	end

	assign stat.cmd        = cmd_q;
	assign stat.full       = used_q == UW'(NUM_SLOTS);
	assign stat.bad_slot   = (int'(slot_q) >= NUM_SLOTS) || !valid_q[slot_sel];
	assign stat.rscan_hit  = rscan_hit;
	assign stat.uscan_done = uscan_done;
	assign stat.dscan_done = dscan_done;
	assign stat.out_free   = out_free;

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign slot_id       = slot_id_q;
	assign timer_running = running_q;
	assign last          = last_q;

endmodule

/* sv/periodic_event_slot_scheduler.sv */
// Channel  Handshake            Word fields
// in       in_valid / in_ready  cmd[1:0] slot[3:0] period[15:0] level[1:0] tick
// out      out_valid/out_ready  kind[2:0] slot_id[3:0] timer_running last
//
// One command at a time. Register searches for the lowest free slot number
// (free slots are searched one per cycle). Unregister and dispatch walk the
// registration order one entry per cycle through the order memory read port;
// dispatch also reads the slot memory. A full output register stalls the
// dispatch walk only when a second firing must leave, and holds the final
// word until the receiver takes the previous one. Reset clears valid bits,
// fill count and handshake state at once; the slot and order memories need
// no clearing pass.
module periodic_event_slot_scheduler import pess_pkg::*; #(
	parameter int NUM_SLOTS   = 16,
	parameter int COUNT_WIDTH = 16,
	parameter int LEVEL_WIDTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [PERIOD_W-1:0]   period,
	input  logic [LEVEL_IN_W-1:0] level,
	input  logic                  tick,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [SLOT_W-1:0]     slot_id,
	output logic                  timer_running,
	output logic                  last
);

	// Commands down, status up; nothing else crosses
	pess_cmd_t  ctl;
	pess_stat_t stat;

	// Sequence one command: decode, scan or walk, then hand over the last word (spare opcodes are dropped)
	pess_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.ctl     (ctl)
	);

	// Slot table, order list, walk pipeline and output register
	pess_datapath #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.LEVEL_WIDTH(LEVEL_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.slot         (slot),
		.period       (period),
		.level        (level),
		.tick         (tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.slot_id      (slot_id),
		.timer_running(timer_running),
		.last         (last)
	);

endmodule

/* sv/pess_checker.sv */
module pess_checker import pess_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [KIND_W-1:0]   kind,
	input logic [SLOT_W-1:0]   slot_id,
	input logic                timer_running,
	input logic                last
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot_id)
			&& $stable(last) && $stable(timer_running))
		else $error("result word changed while stalled");

	// Only firings are followed by more words of the same command
	a_more_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> kind == KIND_FIRED)
		else $error("non-final word that is not a firing");

	// A fresh registration leaves the timer running
	a_reg_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_REG |-> timer_running)
		else $error("registered but timer reported stopped");

	// Full table and empty dispatch carry slot zero
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_FULL || kind == KIND_NONE) |-> slot_id == '0 && last)
		else $error("full or nothing-fired word with nonzero slot");

	// One command at a time: no accept right after an accept
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted word");

endmodule

bind periodic_event_slot_scheduler pess_checker u_pess_checker (.*);

/* tb/tb_periodic_event_slot_scheduler.sv */
// Self-checking bench for the periodic event slot scheduler.
// Commands go in one word at a time on the input channel. A behavioral
// copy of the slot table predicts the result words, and a monitor compares
// every accepted result word against the oldest prediction.
module tb_periodic_event_slot_scheduler;
	import pess_pkg::*;

	localparam int NUM_SLOTS   = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int LEVEL_WIDTH = 2;
	localparam logic [1:0] CMD_SPARE = 2'd3;  // undefined opcode, block must drop it
	localparam int IDLE_PCT    = 19;
	localparam int HOLD_CYCLES = 400;          // long receiver stall
	localparam int DRAIN_TAIL  = 40;           // past a full-table walk
	localparam int STALL_LIMIT = 5000;         // watchdog: cycles without progress
	localparam int RANDOM_WORDS = 270;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] id;
		logic              running;
		logic              last;
	} result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_REG;
	logic [SLOT_W-1:0] slot = '0;
	logic [PERIOD_W-1:0] period = '0;
	logic [LEVEL_IN_W-1:0] level = '0;
	logic tick = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] slot_id;
	logic timer_running;
	logic last;

	// Shadow of the slot table
	bit                   slot_live     [NUM_SLOTS];
	bit [PERIOD_W-1:0]    slot_interval [NUM_SLOTS];
	bit [COUNT_WIDTH-1:0] slot_ticks    [NUM_SLOTS];
	bit [LEVEL_WIDTH-1:0] slot_prio     [NUM_SLOTS];
	bit                   slot_armed    [NUM_SLOTS];
	bit [SLOT_W-1:0]      reg_order     [NUM_SLOTS];
	int                   live_count;

	result_t due_results[$];

	int errors;
	int n_reg, n_full, n_unreg, n_bad, n_disp, n_fired, n_none, n_spare;
	bit steady;       // both sides run without idling
	int hold_epoch;   // bump to make the receiver hold off once

	periodic_event_slot_scheduler #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.LEVEL_WIDTH(LEVEL_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.slot         (slot),
		.period       (period),
		.level        (level),
		.tick         (tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.slot_id      (slot_id),
		.timer_running(timer_running),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		if (errors <= 40)
			$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
	endtask

	function automatic void queue_result(input logic [KIND_W-1:0] k,
			input logic [SLOT_W-1:0] id, input logic lst);
		result_t r;
		r.kind    = k;
		r.id      = id;
		r.running = (live_count != 0);
		r.last    = lst;
		due_results.push_back(r);
	endfunction

	// Apply one accepted command word to the shadow table and queue its results.
	task automatic model_command(input logic [1:0] c, input logic [SLOT_W-1:0] s,
			input logic [PERIOD_W-1:0] p, input logic [LEVEL_IN_W-1:0] l, input logic t);
		int idx, pos, fired, free_slot;
		bit [PERIOD_W-1:0] interval;
		case (c)
		CMD_REG: begin
			free_slot = -1;
			for (idx = NUM_SLOTS - 1; idx >= 0; idx--)
				if (!slot_live[idx])
					free_slot = idx;
			if (free_slot < 0 || live_count >= NUM_SLOTS) begin
				n_full++;
				queue_result(KIND_FULL, '0, 1'b1);
			end else begin
				slot_live[free_slot]     = 1'b1;
				slot_interval[free_slot] = p;
				slot_ticks[free_slot]    = '0;
				slot_prio[free_slot]     = l[LEVEL_WIDTH-1:0];
				slot_armed[free_slot]    = 1'b0;
				reg_order[live_count]    = free_slot[SLOT_W-1:0];
				live_count++;
				n_reg++;
				queue_result(KIND_REG, free_slot[SLOT_W-1:0], 1'b1);
			end
		end
		CMD_UNREG: begin
			if (!slot_live[s]) begin
				n_bad++;
				queue_result(KIND_BAD, s, 1'b1);
			end else begin
				pos = live_count;
				for (idx = live_count - 1; idx >= 0; idx--)
					if (reg_order[idx] == s)
						pos = idx;
				// close the gap in the registration order
				if (pos < live_count) begin
					for (idx = pos; idx + 1 < live_count; idx++)
						reg_order[idx] = reg_order[idx + 1];
					live_count--;
				end
				slot_live[s]  = 1'b0;
				slot_armed[s] = 1'b0;
				n_unreg++;
				queue_result(KIND_UNREG, s, 1'b1);
			end
		end
		CMD_DISP: begin
			n_disp++;
			fired = 0;
			for (pos = 0; pos < live_count; pos++) begin
				idx = reg_order[pos];
				if (t) begin
					slot_ticks[idx] = slot_ticks[idx] + 1'b1;
					interval = (slot_interval[idx] == '0) ? PERIOD_W'(1) : slot_interval[idx];
					if (slot_ticks[idx] >= interval) begin
						slot_armed[idx] = 1'b1;
						slot_ticks[idx] = '0;
					end
				end
				if (slot_armed[idx] && slot_prio[idx] >= l[LEVEL_WIDTH-1:0]
						&& fired < MAX_RESULTS) begin
					slot_armed[idx] = 1'b0;
					queue_result(KIND_FIRED, idx[SLOT_W-1:0], 1'b0);
					fired++;
				end
			end
			if (fired == 0) begin
				n_none++;
				queue_result(KIND_NONE, '0, 1'b1);
			end else begin
				n_fired += fired;
				due_results[$].last = 1'b1;
			end
		end
		default: begin
			n_spare++;
		end
		endcase
	endtask

	// Offer one command word and hold it until the block takes it.
	task automatic send_word(input logic [1:0] c, input logic [SLOT_W-1:0] s,
			input logic [PERIOD_W-1:0] p, input logic [LEVEL_IN_W-1:0] l, input logic t);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		slot     <= s;
		period   <= p;
		level    <= l;
		tick     <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		model_command(c, s, p, l, t);
	endtask

	// Stop offering words until every predicted result has left the block.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Empty table, the special answers, both level bounds, zero and largest period.
	task automatic test_directed();
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b1);      // empty table: nothing fires
		send_word(CMD_UNREG, 4'd5, 16'd0, 2'd0, 1'b0);     // free slot: bad slot
		send_word(CMD_SPARE, 4'd0, 16'd0, 2'd0, 1'b0);     // dropped silently
		send_word(CMD_REG, 4'd0, 16'd0, 2'd0, 1'b0);       // zero period acts as one
		send_word(CMD_REG, 4'd0, 16'd1, 2'd3, 1'b0);
		send_word(CMD_REG, 4'd0, 16'hFFFF, 2'd2, 1'b0);
		send_word(CMD_REG, 4'd0, 16'd2, 2'd1, 1'b0);
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b0);      // no tick, nothing armed
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd3, 1'b1);      // low levels stay armed
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b0);      // leftover armed slot fires
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd1, 1'b1);
		send_word(CMD_UNREG, 4'd1, 16'd0, 2'd0, 1'b0);
		send_word(CMD_UNREG, 4'd1, 16'd0, 2'd0, 1'b0);     // freed twice: bad slot
		send_word(CMD_REG, 4'hF, 16'd3, 2'd3, 1'b1);       // reuses slot 1, goes last
		send_word(CMD_SPARE, 4'hF, 16'hFFFF, 2'd3, 1'b1);
		send_word(CMD_DISP, 4'hF, 16'hFFFF, 2'd0, 1'b1);
		send_word(CMD_UNREG, 4'd0, 16'd0, 2'd0, 1'b0);
		send_word(CMD_UNREG, 4'd2, 16'd0, 2'd0, 1'b0);
		send_word(CMD_UNREG, 4'd3, 16'd0, 2'd0, 1'b0);
		send_word(CMD_UNREG, 4'd1, 16'd0, 2'd0, 1'b0);     // table empty again
		send_word(CMD_UNREG, 4'hF, 16'd0, 2'd0, 1'b0);
		wait_all_results();
	endtask

	// Fill the table behind a stalled receiver, then fire every slot at once.
	task automatic test_full_table_stall();
		int k;
		hold_epoch++;
		for (k = 0; k <= NUM_SLOTS; k++)
			send_word(CMD_REG, SLOT_W'($urandom), PERIOD_W'(k % 2), LEVEL_IN_W'($urandom),
				1'($urandom));
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b1);      // every slot fires
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b0);
		send_word(CMD_DISP, 4'd0, 16'd0, 2'd0, 1'b1);
		wait_all_results();
	endtask

	// Mostly live-slot traffic with small periods; some noise on every field.
	task automatic test_random_traffic();
		int done, pick, reg_pct, unreg_pct;
		logic [PERIOD_W-1:0] p;
		done = 0;
		while (done < RANDOM_WORDS) begin
			steady = (done >= 120 && done < 180);
			if (live_count < 4)
				reg_pct = 45;
			else if (live_count > 12)
				reg_pct = 12;
			else
				reg_pct = 28;
			unreg_pct = (live_count > 12) ? 35 : 20;
			pick = $urandom_range(99);
			pick = (pick < 4) ? -1 : pick - 4;
			pick = (pick < 0) ? -1 : (pick * 100) / 96;
			pick = (pick < 0) ? -1 : pick;
			if (pick < 0) begin
				send_word(CMD_SPARE, SLOT_W'($urandom), PERIOD_W'($urandom),
					LEVEL_IN_W'($urandom), 1'($urandom));
			end else if (pick < reg_pct) begin
				case ($urandom_range(9))
				0: p = PERIOD_W'($urandom);
				1, 2: p = PERIOD_W'($urandom_range(0, 20));
				default: p = PERIOD_W'($urandom_range(0, 4));
				endcase
				send_word(CMD_REG, SLOT_W'($urandom), p, LEVEL_IN_W'($urandom), 1'($urandom));
				done++;
			end else if (pick < reg_pct + unreg_pct) begin
				if (live_count > 0 && $urandom_range(99) < 85)
					send_word(CMD_UNREG, reg_order[$urandom_range(live_count - 1)],
						PERIOD_W'($urandom), LEVEL_IN_W'($urandom), 1'($urandom));
				else
					send_word(CMD_UNREG, SLOT_W'($urandom), PERIOD_W'($urandom),
						LEVEL_IN_W'($urandom), 1'($urandom));
				done++;
			end else begin
				send_word(CMD_DISP, SLOT_W'($urandom), PERIOD_W'($urandom),
					LEVEL_IN_W'($urandom), 1'($urandom_range(99) < 80));
				done++;
			end
		end
		steady = 1'b0;
		wait_all_results();
	endtask

	// Receiver: random back-pressure, a quiet stretch, and one long hold-off.
	initial begin : receiver
		int hold_left, seen_epoch;
		hold_left  = 0;
		seen_epoch = 0;
		forever begin
			@(posedge clk);
			if (hold_epoch != seen_epoch) begin
				seen_epoch = hold_epoch;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("unexpected result word, kind", -1, kind);
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", want.kind, kind);
				if (slot_id !== want.id)
					report_mismatch("slot_id", want.id, slot_id);
				if (timer_running !== want.running)
					report_mismatch("timer_running", want.running, timer_running);
				if (last !== want.last)
					report_mismatch("last", want.last, last);
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no word moving.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no progress for %0d cycles, %0d results still due",
			STALL_LIMIT, due_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		errors     = 0;
		live_count = 0;
		steady     = 1'b0;
		hold_epoch = 0;
		foreach (slot_live[i])
			slot_live[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table_stall();
		test_random_traffic();

		if (due_results.size() != 0)
			report_mismatch("results never delivered", 0, due_results.size());
		$display("covered %0d registers (%0d table full), %0d unregisters (%0d bad slot),",
			n_reg, n_full, n_unreg, n_bad);
		$display("  %0d dispatches with %0d firings and %0d empty, %0d dropped opcodes",
			n_disp, n_fired, n_none, n_spare);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
sv/pess_pkg.sv
sv/pess_ram.sv
sv/pess_ctrl.sv
sv/pess_datapath.sv
sv/periodic_event_slot_scheduler.sv
sv/pess_checker.sv
tb/tb_periodic_event_slot_scheduler.sv
